FILE: hdl/min_heap_priority_queue_unit_defines.svh
// Assertion macros used by the heap queue datapath.
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Expression holds at every rising clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/mhpq_pkg.sv
// Types and constants of the min-heap priority queue.
package mhpq_pkg;

  localparam int KEY_W     = 32;
  localparam int TAG_W     = 16;
  localparam int CNT_OUT_W = 11;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } hq_status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_UP_CMP,
    S_REM_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic ins_start;
    logic rem_start;
    logic mark_full;
    logic mark_empty;
    logic take_last;
    logic up_read;
    logic up_step;
    logic dn_read;
    logic dn_step;
    logic place;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_swap;
    logic dn_swap;
  } dp_stat_t;

endpackage

FILE: hdl/min_heap_priority_queue_unit.sv
// Top level of the bounded binary min-heap priority queue.
//
//  channel  | handshake            | words
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_ready  | action, key, tag
//  output   | out_valid / out_ready| status, removed_key, removed_tag, head_key,
//           |                      | head_tag, head_valid, entry_count
//
// One word is worked at a time: a full insert or an empty remove goes straight to the
// output register; an insert starts from the end slot and climbs level by level while
// the parent key is greater; a remove takes the root and, unless that empties the heap,
// moves the last entry to the root and sifts it down; each result is then registered.
// rst is synchronous and clears only the fill count and control state, not the memory.
// in_ready is high only while idle; a stalled output holds the next result in place.
module min_heap_priority_queue_unit import mhpq_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [KEY_W-1:0]     key,
  input  logic [TAG_W-1:0]     tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [KEY_W-1:0]     removed_key,
  output logic [TAG_W-1:0]     removed_tag,
  output logic [KEY_W-1:0]     head_key,
  output logic [TAG_W-1:0]     head_tag,
  output logic                 head_valid,
  output logic [CNT_OUT_W-1:0] entry_count
);

  // command and status bundles between the sequencer and the datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: accepts a word, walks the sift loop, loads the result word
  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: heap memory, moving entry, root shadow and result registers
  mhpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .key_in      (key),
    .tag_in      (tag),
    .status      (status),
    .removed_key (removed_key),
    .removed_tag (removed_tag),
    .head_key    (head_key),
    .head_tag    (head_tag),
    .head_valid  (head_valid),
    .entry_count (entry_count)
  );

endmodule

FILE: hdl/mhpq_ctrl.sv
// Sequencer for insert, remove and the sift walks of the heap queue.
module mhpq_ctrl import mhpq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     action,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == ACT_INSERT) begin
            if (stat.full) begin
              cmd.mark_full = 1'b1;
              state_next    = S_FIN;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = S_INS_CHK;
            end
          end else begin
            if (stat.empty) begin
              cmd.mark_empty = 1'b1;
              state_next     = S_FIN;
            end else begin
              cmd.rem_start = 1'b1;
              state_next    = S_REM_LAST;
            end
          end
        end
      end
      S_INS_CHK: begin
        if (stat.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.up_read = 1'b1;
          state_next  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_swap) begin
          cmd.up_step = 1'b1;
          state_next  = S_INS_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FIN;
        end
      end
      S_REM_LAST: begin
        // last entry was the root itself: nothing to sift
        if (stat.empty) begin
          state_next = S_FIN;
        end else begin
          cmd.take_last = 1'b1;
          state_next    = S_DN_RD;
        end
      end
      S_DN_RD: begin
        cmd.dn_read = 1'b1;
        state_next  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.dn_swap) begin
          cmd.dn_step = 1'b1;
          state_next  = S_DN_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: hdl/mhpq_dp.sv
// Heap storage, moving-entry registers, fill count and result registers.
`include "min_heap_priority_queue_unit_defines.svh"

module mhpq_dp import mhpq_pkg::*; #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [KEY_W-1:0]     key_in,
  input  logic [TAG_W-1:0]     tag_in,
  output logic [1:0]           status,
  output logic [KEY_W-1:0]     removed_key,
  output logic [TAG_W-1:0]     removed_tag,
  output logic [KEY_W-1:0]     head_key,
  output logic [TAG_W-1:0]     head_tag,
  output logic                 head_valid,
  output logic [CNT_OUT_W-1:0] entry_count
);

  entry_t           mem [DEPTH];
  entry_t           rd_a, rd_b;
  entry_t           mv;
  entry_t           head;
  entry_t           rm;
  hq_status_t       res_status;
  logic [AW-1:0]    pos;
  logic [CW-1:0]    count;

  hq_status_t       o_status;
  entry_t           o_rm;
  entry_t           o_head;
  logic             o_head_valid;
  logic [CNT_OUT_W-1:0] o_count;

  logic [AW-1:0]    pos_m1, parent, last_idx, best_idx, addr_a;
  logic [AW+1:0]    lc, rc, cnt_x;
  logic             left_lt, right_lt;
  logic [KEY_W-1:0] best_key;
  entry_t           best_ent, wr_data;
  logic             wr_en, rd_a_en;

  always_comb begin
    pos_m1   = pos - AW'(1);
    parent   = pos_m1 >> 1;
    last_idx = AW'(count - CW'(1));
    lc       = {1'b0, pos, 1'b1};
    rc       = {1'b0, pos, 1'b0} + (AW+2)'(2);
    cnt_x    = (AW+2)'(count);
    left_lt  = (lc < cnt_x) && (rd_a.key < mv.key);
    best_key = left_lt ? rd_a.key : mv.key;
    right_lt = (rc < cnt_x) && (rd_b.key < best_key);
    best_ent = right_lt ? rd_b : rd_a;
    best_idx = right_lt ? rc[AW-1:0] : lc[AW-1:0];

    wr_en   = cmd.up_step | cmd.dn_step | cmd.place;
    wr_data = cmd.place ? mv : (cmd.up_step ? rd_a : best_ent);
    rd_a_en = cmd.rem_start | cmd.up_read | cmd.dn_read;
    addr_a  = cmd.rem_start ? last_idx : (cmd.up_read ? parent : lc[AW-1:0]);

    stat.full     = (count == CW'(DEPTH));
    stat.empty    = (count == '0);
    stat.pos_zero = (pos == '0);
    stat.up_swap  = (rd_a.key > mv.key);
    stat.dn_swap  = left_lt | right_lt;
  end

  // storage: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a <= mem[addr_a];
    end
    if (cmd.dn_read) begin
      rd_b <= mem[rc[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_start) begin
      count <= count + CW'(1);
    end else if (cmd.rem_start) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    // shadow the root so the head is known without a read
    if (wr_en && (pos == '0)) begin
      head <= wr_data;
    end
    if (cmd.ins_start) begin
      mv         <= '{key: key_in, tag: tag_in};
      pos        <= AW'(count);
      res_status <= ST_DONE;
      rm         <= '0;
    end
    if (cmd.rem_start) begin
      rm         <= head;
      res_status <= ST_DONE;
    end
    if (cmd.mark_full) begin
      res_status <= ST_FULL;
      rm         <= '0;
    end
    if (cmd.mark_empty) begin
      res_status <= ST_EMPTY;
      rm         <= '0;
    end
    if (cmd.take_last) begin
      mv  <= rd_a;
      pos <= '0;
    end
    if (cmd.up_step) begin
      pos <= parent;
    end
    if (cmd.dn_step) begin
      pos <= best_idx;
    end
    if (cmd.load_out) begin
      o_status     <= res_status;
      o_rm         <= rm;
      o_head_valid <= (count != '0);
      o_head       <= (count != '0) ? head : '0;
      o_count      <= CNT_OUT_W'(count);
    end
  end

  assign status      = o_status;
  assign removed_key = o_rm.key;
  assign removed_tag = o_rm.tag;
  assign head_key    = o_head.key;
  assign head_tag    = o_head.tag;
  assign head_valid  = o_head_valid;
  assign entry_count = o_count;

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `ASSERT_NEXT(a_ins_grows, clk, rst, cmd.ins_start, count == $past(count) + CW'(1))
  `ASSERT_NEXT(a_rem_shrinks, clk, rst, cmd.rem_start, count == $past(count) - CW'(1))
  `ASSERT_IMPLY(a_wr_in_heap, clk, rst, wr_en, (AW+2)'(pos) < cnt_x)

endmodule

FILE: dv/testbench.sv
// Testbench for the min-heap priority queue: directed table, random traffic, heap predictor.
module testbench;
  import mhpq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 1024;
  localparam int CYCLE_CAP = 600000;
  localparam int MAX_SHOWN = 10;

  // One result word as the block presents it.
  typedef struct packed {
    hq_status_t           status;
    logic [KEY_W-1:0]     removed_key;
    logic [TAG_W-1:0]     removed_tag;
    logic [KEY_W-1:0]     head_key;
    logic [TAG_W-1:0]     head_tag;
    logic                 head_valid;
    logic [CNT_OUT_W-1:0] entry_count;
  } heap_result_t;

  // One row of the directed table; typed rows carry their own expected word.
  typedef struct {
    logic             act;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    bit               typed;
    heap_result_t     want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 action = ACT_INSERT;
  logic [KEY_W-1:0]     key = '0;
  logic [TAG_W-1:0]     tag = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic [KEY_W-1:0]     removed_key;
  logic [TAG_W-1:0]     removed_tag;
  logic [KEY_W-1:0]     head_key;
  logic [TAG_W-1:0]     head_tag;
  logic                 head_valid;
  logic [CNT_OUT_W-1:0] entry_count;

  // Predicted heap contents and fill level.
  entry_t heap_slots [DEPTH];
  int     heap_fill = 0;

  heap_result_t expected_results [$];
  stim_row_t    plan [$];

  int  words_sent   = 0;
  int  words_seen   = 0;
  int  mismatches   = 0;
  int  full_drops   = 0;
  int  empty_pulls  = 0;
  int  peak_fill    = 0;
  int  cycles       = 0;
  bit  quiet        = 1'b0;  // no idling on either side while set
  bit  hold_off     = 1'b0;  // receiver refuses every word while set

  min_heap_priority_queue_unit #(.DEPTH(DEPTH)) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one word to the predicted heap and return the word the block should emit.
  function automatic heap_result_t heap_apply(logic act, logic [KEY_W-1:0] k,
                                              logic [TAG_W-1:0] t);
    heap_result_t r;
    entry_t       tmp;
    int           pos;
    int           up;
    int           lc;
    int           rc;
    int           best;
    r = '0;
    r.status = ST_DONE;
    if (act == ACT_INSERT) begin
      if (heap_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // Append, then climb while the parent is strictly greater.
        heap_slots[heap_fill] = '{key: k, tag: t};
        pos = heap_fill;
        heap_fill++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (heap_slots[up].key <= heap_slots[pos].key) break;
          tmp = heap_slots[up];
          heap_slots[up] = heap_slots[pos];
          heap_slots[pos] = tmp;
          pos = up;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // Take the root, move the last entry up and sink it; left child wins ties.
        r.removed_key = heap_slots[0].key;
        r.removed_tag = heap_slots[0].tag;
        heap_slots[0] = heap_slots[heap_fill-1];
        heap_fill--;
        pos = 0;
        while (1) begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          best = pos;
          if (lc < heap_fill && heap_slots[lc].key < heap_slots[best].key) best = lc;
          if (rc < heap_fill && heap_slots[rc].key < heap_slots[best].key) best = rc;
          if (best == pos) break;
          tmp = heap_slots[pos];
          heap_slots[pos] = heap_slots[best];
          heap_slots[best] = tmp;
          pos = best;
        end
      end
    end
    if (heap_fill != 0) begin
      r.head_key   = heap_slots[0].key;
      r.head_tag   = heap_slots[0].tag;
      r.head_valid = 1'b1;
    end
    r.entry_count = heap_fill[CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t plan_row(logic act, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                                         bit typed = 1'b0, hq_status_t st = ST_DONE,
                                         logic [KEY_W-1:0] rk = '0, logic [TAG_W-1:0] rt = '0,
                                         logic [KEY_W-1:0] hk = '0, logic [TAG_W-1:0] ht = '0,
                                         logic hv = 1'b0, logic [CNT_OUT_W-1:0] cnt = '0);
    stim_row_t r;
    r.act   = act;
    r.key   = k;
    r.tag   = t;
    r.typed = typed;
    r.want  = '{status: st, removed_key: rk, removed_tag: rt, head_key: hk,
                head_tag: ht, head_valid: hv, entry_count: cnt};
    return r;
  endfunction

  // Keys lean toward small values so equal keys and ties between children are common.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(0, 15);
      5:       return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  // Offer one word on the input channel and hold it until accepted.
  // Called right after a falling edge; returns right after a falling edge once the word is taken.
  task automatic offer_word(logic act, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                            bit typed, heap_result_t want);
    heap_result_t predicted;
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    key      <= k;
    tag      <= t;
    do @(posedge clk); while (!in_ready);
    predicted = heap_apply(act, k, t);
    expected_results.push_back(typed ? want : predicted);
    words_sent++;
    if (predicted.status == ST_FULL) full_drops++;
    if (predicted.status == ST_EMPTY) empty_pulls++;
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    @(negedge clk);
  endtask

  // Receiver: ready changes at the falling edge, idles at random unless quiet or held off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 8);
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the input stalls.
  initial begin
    wait (words_sent >= 120);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (250) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    heap_result_t want;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("ERROR: result word with nothing expected: status=%0d head_key=%h count=%0d",
                   status, head_key, entry_count);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || removed_key !== want.removed_key ||
            removed_tag !== want.removed_tag || head_key !== want.head_key ||
            head_tag !== want.head_tag || head_valid !== want.head_valid ||
            entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("ERROR: result %0d expected st=%0d rm=%h/%h head=%h/%h hv=%b cnt=%0d",
                     words_seen, want.status, want.removed_key, want.removed_tag,
                     want.head_key, want.head_tag, want.head_valid, want.entry_count);
            $display("       result %0d actual   st=%0d rm=%h/%h head=%h/%h hv=%b cnt=%0d",
                     words_seen, status, removed_key, removed_tag,
                     head_key, head_tag, head_valid, entry_count);
          end
        end
      end
    end
  end

  // Cap on the run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("ERROR: timeout with %0d results still expected", expected_results.size());
      $display("** min_heap_priority_queue_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic act;

    // Directed table. Rows with typed expectations are read straight off the spec:
    // empty heap, key and tag extremes, and the empty-remove status.
    plan.push_back(plan_row(ACT_REMOVE, '0, '0, 1'b1, ST_EMPTY));
    plan.push_back(plan_row(ACT_INSERT, '1, '1, 1'b1, ST_DONE, '0, '0, '1, '1, 1'b1,
                            CNT_OUT_W'(1)));
    plan.push_back(plan_row(ACT_INSERT, '0, '0, 1'b1, ST_DONE, '0, '0, '0, '0, 1'b1,
                            CNT_OUT_W'(2)));
    plan.push_back(plan_row(ACT_REMOVE, '0, '0, 1'b1, ST_DONE, '0, '0, '1, '1, 1'b1,
                            CNT_OUT_W'(1)));
    plan.push_back(plan_row(ACT_REMOVE, '0, '0, 1'b1, ST_DONE, '1, '1, '0, '0, 1'b0,
                            CNT_OUT_W'(0)));
    plan.push_back(plan_row(ACT_REMOVE, '0, '0, 1'b1, ST_EMPTY));
    // Equal keys: an equal parent must not move, and the left child wins a tie on the way down.
    plan.push_back(plan_row(ACT_INSERT, 5, 16'h0001));
    plan.push_back(plan_row(ACT_INSERT, 5, 16'h0002));
    plan.push_back(plan_row(ACT_INSERT, 5, 16'h0003));
    plan.push_back(plan_row(ACT_INSERT, 9, 16'h0004));
    plan.push_back(plan_row(ACT_INSERT, 3, 16'h0005));
    plan.push_back(plan_row(ACT_INSERT, 5, 16'h0006));
    plan.push_back(plan_row(ACT_INSERT, 7, 16'h0007));
    plan.push_back(plan_row(ACT_INSERT, 32'h8000_0000, 16'hAAAA));
    plan.push_back(plan_row(ACT_INSERT, 32'h7FFF_FFFF, 16'h5555));
    plan.push_back(plan_row(ACT_REMOVE, '0, '0));
    plan.push_back(plan_row(ACT_REMOVE, '0, '0));
    plan.push_back(plan_row(ACT_REMOVE, '0, '0));
    plan.push_back(plan_row(ACT_REMOVE, '0, '0));
    plan.push_back(plan_row(ACT_INSERT, '0, 16'h8000));
    plan.push_back(plan_row(ACT_REMOVE, '0, '0));
    plan.push_back(plan_row(ACT_REMOVE, '0, '0));

    // Hold reset, then release it at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i])
      offer_word(plan[i].act, plan[i].key, plan[i].tag, plan[i].typed, plan[i].want);

    // Mixed traffic: balanced first so the heap empties often, then biased to grow.
    for (int i = 0; i < 370; i++) begin
      quiet <= (i >= 150 && i < 250);
      act = ($urandom_range(99) < (i < 150 ? 50 : 62)) ? ACT_INSERT : ACT_REMOVE;
      offer_word(act, pick_key(), TAG_W'($urandom_range(0, 65535)), 1'b0, '0);
    end
    quiet <= 1'b0;

    // Drain the whole heap so every stored entry comes out in order, then pull on empty and insert once.
    while (heap_fill > 0)
      offer_word(ACT_REMOVE, pick_key(), TAG_W'($urandom_range(0, 65535)), 1'b0, '0);
    offer_word(ACT_REMOVE, pick_key(), TAG_W'($urandom_range(0, 65535)), 1'b0, '0);
    offer_word(ACT_INSERT, pick_key(), TAG_W'($urandom_range(0, 65535)), 1'b0, '0);
    in_valid <= 1'b0;

    // Wait out every outstanding result, then wait on to catch any stray words.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d words: peak fill %0d of %0d, %0d inserts dropped on a full heap,",
             words_sent, peak_fill, DEPTH, full_drops);
    $display("%0d removes on an empty heap; %0d results checked, %0d mismatches.",
             empty_pulls, words_seen, mismatches);
    if (mismatches == 0) begin
      $display("** min_heap_priority_queue_unit: PASSED **");
    end else begin
      $display("** min_heap_priority_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
